// ----- rtl/core/ectc_pkg.sv -----
`default_nettype none

package ectc_pkg;

  // Field widths
  localparam int unsigned SecsW   = 32;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned Hour24W = 5;
  localparam int unsigned Hour12W = 4;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;

  // Internal widths
  localparam int unsigned DaysW    = 16;  // day count since epoch, up to 49710
  localparam int unsigned TodW     = 17;  // second of day, up to 86399
  localparam int unsigned HourRemW = 12;  // second of hour, up to 3599
  localparam int unsigned CycleW   = 6;   // four-year cycles since 1968-03-01
  localparam int unsigned DocW     = 11;  // day of cycle, up to 1460
  localparam int unsigned DoyW     = 9;   // March-based day of year, up to 365
  localparam int unsigned YoeW     = 2;   // year of cycle
  localparam int unsigned MonIdxW  = 4;   // March-based month index

  // Pipeline depth ahead of the output register
  localparam int unsigned NumStages = 7;
  typedef logic [NumStages-1:0] stage_en_t;

  // Time constants
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;

  // seconds / 86400 == ((seconds >> 7) * DayRecip) >> DayShift, exact for 32-bit input
  localparam int unsigned DayPreShift = 7;
  localparam int unsigned DayRecipW   = 26;
  localparam int unsigned DayRecip    = 50903317;
  localparam int unsigned DayShift    = 35;

  // second of day / 3600 == ((tod >> 4) * HourRecip) >> 20
  localparam int unsigned HourPreShift = 4;
  localparam int unsigned HourRecipW   = 13;
  localparam int unsigned HourRecip    = 4661;
  localparam int unsigned HourShift    = 20;

  // second of hour / 60 == ((rem >> 2) * MinRecip) >> 14
  localparam int unsigned MinPreShift = 2;
  localparam int unsigned MinRecipW   = 11;
  localparam int unsigned MinRecip    = 1093;
  localparam int unsigned MinShift    = 14;

  // Calendar counted from 1968-03-01 so the leap day closes each four-year cycle
  localparam int unsigned BaseYear     = 1968;
  localparam int unsigned EraOffset    = 671;    // days from 1968-03-01 to 1970-01-01
  localparam int unsigned SkipDay      = 48212;  // 2100-03-01, first day after the missing leap day
  localparam int unsigned DaysPerCycle = 1461;
  localparam int unsigned CycleRecip   = 45934;  // day / 1461 == (day * CycleRecip) >> 26
  localparam int unsigned CycleShift   = 26;
  localparam int unsigned DaysPerYear  = 365;
  localparam int unsigned YearRecip    = 1437;   // doc / 365 == (doc * YearRecip) >> 19
  localparam int unsigned YearShift    = 19;
  localparam int unsigned MaxYoe       = 3;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned JanIdx        = 10;    // March-based index of January

  // First day of each March-based month within the year
  function automatic logic [DoyW-1:0] month_start(input logic [MonIdxW-1:0] idx);
    logic [DoyW-1:0] start;
    unique case (idx)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ectc_if.sv -----
`default_nettype none

// Input channel: one epoch second count per beat
interface ectc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ectc_pkg::SecsW-1:0]  epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// Output channel: one calendar date and time per beat
interface ectc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ectc_pkg::YearW-1:0]    year;
  logic [ectc_pkg::MonthW-1:0]   month;
  logic [ectc_pkg::DayW-1:0]     day_of_month;
  logic [ectc_pkg::Hour24W-1:0]  hour_24;
  logic [ectc_pkg::Hour12W-1:0]  hour_12;
  logic                          is_pm;
  logic [ectc_pkg::MinW-1:0]     minute;
  logic [ectc_pkg::SecW-1:0]     second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour_24, output hour_12, output is_pm, output minute,
                  output second, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour_24, input hour_12, input is_pm, input minute,
                  input second, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/epoch_to_calendar_time.sv -----
// Epoch seconds to calendar date and time.
//
// in_i carries one epoch second count per beat (already shifted to local
// time); out_o carries the Gregorian year, month, day of month, 24-hour and
// 12-hour hour, PM flag, minute and second for it, one beat per input beat,
// in order. Every 32-bit value is a valid time (up to 2106-02-07 06:28:15).
//
// A beat accepted on in_i passes through the seven pipeline stages (day
// split by reciprocal multiply, then cycle, year and month of the date in
// parallel with hour, minute and second) and the output register to out_o.
// Throughput is one beat per cycle while the receiver does not stall out_o.
//
// Reset clears the stage valid bits and the output valid; no beat is in
// flight afterwards. When the receiver stalls, the result holds on out_o and
// the stages behind it keep filling, closing any bubbles; in_i.ready drops
// only once every stage holds a beat.
`default_nettype none

module epoch_to_calendar_time (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ectc_in_if.sink   in_i,
  ectc_out_if.source out_o
);

  localparam int unsigned DayXW = ectc_pkg::SecsW - ectc_pkg::DayPreShift;
  localparam int unsigned DayPW = DayXW + ectc_pkg::DayRecipW;
  localparam int unsigned N     = ectc_pkg::NumStages;

  ectc_pkg::stage_en_t              en;
  logic [N-1:0]                     v_q, v_d;
  logic                             out_v_q;
  logic                             out_rdy;

  logic [ectc_pkg::SecsW-1:0]       secs_1_q, secs_2_q;
  logic [DayPW-1:0]                 day_prod_d, day_prod_q;
  logic [ectc_pkg::DaysW-1:0]       days_d, days_q;
  logic [ectc_pkg::SecsW:0]         day_secs;
  logic [ectc_pkg::TodW-1:0]        tod_d, tod_q;

  logic [ectc_pkg::YearW-1:0]       year_d, year_q;
  logic [ectc_pkg::MonthW-1:0]      month_d, month_q;
  logic [ectc_pkg::DayW-1:0]        dom_d, dom_q;
  logic [ectc_pkg::Hour24W-1:0]     h24_d, h24_q;
  logic [ectc_pkg::Hour12W-1:0]     h12_d, h12_q;
  logic                             pm_d, pm_q;
  logic [ectc_pkg::MinW-1:0]        mn_d, mn_q;
  logic [ectc_pkg::SecW-1:0]        sc_d, sc_q;

  // Stage loads when empty or when the stage after it moves
  always_comb begin
    out_rdy   = !out_v_q || out_o.ready;
    en[N-1]   = !v_q[N-1] || out_rdy;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < N; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q <= v_d;
      if (out_rdy) begin
        out_v_q <= v_q[N-1];
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      secs_1_q <= in_i.epoch_seconds;
    end
  end

  // Day count by reciprocal multiply
  assign day_prod_d = DayPW'(secs_1_q[ectc_pkg::SecsW-1:ectc_pkg::DayPreShift])
                    * DayPW'(ectc_pkg::DayRecip);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      day_prod_q <= day_prod_d;
      secs_2_q   <= secs_1_q;
    end
  end

  // Split into whole days and second of day
  always_comb begin
    days_d   = day_prod_q[ectc_pkg::DayShift +: ectc_pkg::DaysW];
    day_secs = (ectc_pkg::SecsW + 1)'(days_d)
             * (ectc_pkg::SecsW + 1)'(ectc_pkg::SecsPerDay);
    tod_d    = ectc_pkg::TodW'(secs_2_q - day_secs[ectc_pkg::SecsW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      days_q <= days_d;
      tod_q  <= tod_d;
    end
  end

  ectc_date u_date (
    .clk_i          (clk_i),
    .en_i           (en),
    .days_i         (days_q),
    .year_o         (year_d),
    .month_o        (month_d),
    .day_of_month_o (dom_d)
  );

  ectc_tod u_tod (
    .clk_i     (clk_i),
    .en_i      (en),
    .tod_i     (tod_q),
    .hour_24_o (h24_d),
    .hour_12_o (h12_d),
    .is_pm_o   (pm_d),
    .minute_o  (mn_d),
    .second_o  (sc_d)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      year_q  <= year_d;
      month_q <= month_d;
      dom_q   <= dom_d;
      h24_q   <= h24_d;
      h12_q   <= h12_d;
      pm_q    <= pm_d;
      mn_q    <= mn_d;
      sc_q    <= sc_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.year         = year_q;
  assign out_o.month        = month_q;
  assign out_o.day_of_month = dom_q;
  assign out_o.hour_24      = h24_q;
  assign out_o.hour_12      = h12_q;
  assign out_o.is_pm        = pm_q;
  assign out_o.minute       = mn_q;
  assign out_o.second       = sc_q;

  // Input backs up only when every stage is full and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready && v_q == '1))
    else $error("input stalled while the pipeline has room");

  // A finished beat in the last stage reaches the output when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[N-1] && out_rdy) |=> out_o.valid)
    else $error("last stage beat lost on the way to the output");

  // Date and time fields stay in their calendar ranges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.month >= 4'd1 && out_o.month <= 4'd12 &&
                     out_o.day_of_month >= 5'd1 && out_o.hour_24 <= 5'd23 &&
                     out_o.minute <= 6'd59 && out_o.second <= 6'd59))
    else $error("calendar field out of range");

  // PM flag and 12-hour hour agree with the 24-hour hour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.is_pm == (out_o.hour_24 >= 5'd12) &&
                     out_o.hour_12 >= 4'd1 && out_o.hour_12 <= 4'd12))
    else $error("12-hour fields disagree with hour_24");

endmodule

`default_nettype wire

// ----- rtl/core/ectc_tod.sv -----
`default_nettype none

module ectc_tod (
  input  wire logic                            clk_i,
  input  wire ectc_pkg::stage_en_t             en_i,
  input  wire logic [ectc_pkg::TodW-1:0]       tod_i,
  output logic      [ectc_pkg::Hour24W-1:0]    hour_24_o,
  output logic      [ectc_pkg::Hour12W-1:0]    hour_12_o,
  output logic                                 is_pm_o,
  output logic      [ectc_pkg::MinW-1:0]       minute_o,
  output logic      [ectc_pkg::SecW-1:0]       second_o
);

  localparam int unsigned HourXW = ectc_pkg::TodW - ectc_pkg::HourPreShift;
  localparam int unsigned HourPW = HourXW + ectc_pkg::HourRecipW;
  localparam int unsigned MinXW  = ectc_pkg::HourRemW - ectc_pkg::MinPreShift;
  localparam int unsigned MinPW  = MinXW + ectc_pkg::MinRecipW;

  logic [HourPW-1:0]                   hour_prod;
  logic [ectc_pkg::Hour24W-1:0]        h24_d, h24_4_q, h24_5_q, h24_6_q, h24_7_q;
  logic [ectc_pkg::TodW-1:0]           tod_4_q;
  logic [ectc_pkg::TodW-1:0]           hour_secs;
  logic [ectc_pkg::HourRemW-1:0]       rem_d, rem_5_q, rem_6_q;
  logic [MinPW-1:0]                    min_prod;
  logic [ectc_pkg::MinW-1:0]           mn_d, mn_6_q, mn_7_q;
  logic [ectc_pkg::HourRemW-1:0]       min_secs;
  logic [ectc_pkg::SecW-1:0]           sc_d, sc_7_q;

  // Hour of day by reciprocal multiply
  always_comb begin
    hour_prod = HourPW'(tod_i[ectc_pkg::TodW-1:ectc_pkg::HourPreShift])
              * HourPW'(ectc_pkg::HourRecip);
    h24_d     = hour_prod[ectc_pkg::HourShift +: ectc_pkg::Hour24W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      h24_4_q <= h24_d;
      tod_4_q <= tod_i;
    end
  end

  // Strip whole hours
  always_comb begin
    hour_secs = ectc_pkg::TodW'(h24_4_q) * ectc_pkg::TodW'(ectc_pkg::SecsPerHour);
    rem_d     = ectc_pkg::HourRemW'(tod_4_q - hour_secs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      h24_5_q <= h24_4_q;
      rem_5_q <= rem_d;
    end
  end

  // Minute by reciprocal multiply
  always_comb begin
    min_prod = MinPW'(rem_5_q[ectc_pkg::HourRemW-1:ectc_pkg::MinPreShift])
             * MinPW'(ectc_pkg::MinRecip);
    mn_d     = min_prod[ectc_pkg::MinShift +: ectc_pkg::MinW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      h24_6_q <= h24_5_q;
      rem_6_q <= rem_5_q;
      mn_6_q  <= mn_d;
    end
  end

  // Second is what the minutes leave
  always_comb begin
    min_secs = ectc_pkg::HourRemW'(mn_6_q) * ectc_pkg::HourRemW'(ectc_pkg::SecsPerMin);
    sc_d     = ectc_pkg::SecW'(rem_6_q - min_secs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      h24_7_q <= h24_6_q;
      mn_7_q  <= mn_6_q;
      sc_7_q  <= sc_d;
    end
  end

  // Fold to 12-hour form; midnight and noon read 12
  always_comb begin
    hour_24_o = h24_7_q;
    minute_o  = mn_7_q;
    second_o  = sc_7_q;
    is_pm_o   = (h24_7_q >= 5'd12);
    if (h24_7_q == 5'd0) begin
      hour_12_o = 4'd12;
    end else if (h24_7_q > 5'd12) begin
      hour_12_o = ectc_pkg::Hour12W'(h24_7_q - 5'd12);
    end else begin
      hour_12_o = ectc_pkg::Hour12W'(h24_7_q);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ectc_date.sv -----
`default_nettype none

module ectc_date (
  input  wire logic                           clk_i,
  input  wire ectc_pkg::stage_en_t            en_i,
  input  wire logic [ectc_pkg::DaysW-1:0]     days_i,
  output logic      [ectc_pkg::YearW-1:0]     year_o,
  output logic      [ectc_pkg::MonthW-1:0]    month_o,
  output logic      [ectc_pkg::DayW-1:0]      day_of_month_o
);

  localparam int unsigned CycPW  = 2 * ectc_pkg::DaysW;
  localparam int unsigned YearPW = 2 * ectc_pkg::DocW;

  logic [ectc_pkg::DaysW-1:0]    dp_base, dp_d, dp_4_q, dp_5_q;
  logic [CycPW-1:0]              cyc_prod;
  logic [ectc_pkg::CycleW-1:0]   cyc_d, cyc_5_q, cyc_6_q, cyc_7_q;
  logic [ectc_pkg::DaysW-1:0]    cyc_days;
  logic [ectc_pkg::DocW-1:0]     doc_d, doc_6_q;
  logic [YearPW-1:0]             year_prod;
  logic [2:0]                    yoe_raw;
  logic [ectc_pkg::YoeW-1:0]     yoe_d, yoe_7_q;
  logic [ectc_pkg::DocW-1:0]     yoe_days;
  logic [ectc_pkg::DoyW-1:0]     doy_d, doy_7_q;
  logic [ectc_pkg::MonIdxW-1:0]  mp;
  logic [ectc_pkg::DoyW-1:0]     day_idx;

  // Rebase to 1968-03-01; insert the leap day that 2100 lacks
  always_comb begin
    dp_base = days_i + ectc_pkg::DaysW'(ectc_pkg::EraOffset);
    dp_d    = (dp_base >= ectc_pkg::DaysW'(ectc_pkg::SkipDay))
            ? dp_base + 1'b1 : dp_base;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      dp_4_q <= dp_d;
    end
  end

  // Four-year cycle number
  always_comb begin
    cyc_prod = CycPW'(dp_4_q) * CycPW'(ectc_pkg::CycleRecip);
    cyc_d    = cyc_prod[ectc_pkg::CycleShift +: ectc_pkg::CycleW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      dp_5_q  <= dp_4_q;
      cyc_5_q <= cyc_d;
    end
  end

  // Day within the cycle
  always_comb begin
    cyc_days = ectc_pkg::DaysW'(cyc_5_q) * ectc_pkg::DaysW'(ectc_pkg::DaysPerCycle);
    doc_d    = ectc_pkg::DocW'(dp_5_q - cyc_days);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      cyc_6_q <= cyc_5_q;
      doc_6_q <= doc_d;
    end
  end

  // Year of cycle, clamped so the leap day stays in the fourth year
  always_comb begin
    year_prod = YearPW'(doc_6_q) * YearPW'(ectc_pkg::YearRecip);
    yoe_raw   = year_prod[ectc_pkg::YearShift +: 3];
    yoe_d     = (yoe_raw > 3'(ectc_pkg::MaxYoe)) ? ectc_pkg::YoeW'(ectc_pkg::MaxYoe)
                                                 : yoe_raw[ectc_pkg::YoeW-1:0];
    yoe_days  = ectc_pkg::DocW'(yoe_d) * ectc_pkg::DocW'(ectc_pkg::DaysPerYear);
    doy_d     = ectc_pkg::DoyW'(doc_6_q - yoe_days);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      cyc_7_q <= cyc_6_q;
      yoe_7_q <= yoe_d;
      doy_7_q <= doy_d;
    end
  end

  // Month search, then fold March-based month back to January-based year
  always_comb begin
    mp = '0;
    for (int i = 1; i < ectc_pkg::MonthsPerYear; i++) begin
      if (doy_7_q >= ectc_pkg::month_start(ectc_pkg::MonIdxW'(i))) begin
        mp = ectc_pkg::MonIdxW'(i);
      end
    end
    day_idx        = doy_7_q - ectc_pkg::month_start(mp);
    day_of_month_o = ectc_pkg::DayW'(day_idx) + 1'b1;
    if (mp < ectc_pkg::MonIdxW'(ectc_pkg::JanIdx)) begin
      month_o = mp + 4'd3;
    end else begin
      month_o = mp - 4'd9;
    end
    year_o = ectc_pkg::YearW'(ectc_pkg::BaseYear)
           + ectc_pkg::YearW'({cyc_7_q, 2'b00})
           + ectc_pkg::YearW'(yoe_7_q)
           + ectc_pkg::YearW'(mp >= ectc_pkg::MonIdxW'(ectc_pkg::JanIdx));
  end

endmodule

`default_nettype wire

// ----- test/tb_epoch_to_calendar_time.sv -----
`timescale 1ns / 100ps

module tb_epoch_to_calendar_time;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 16;

  typedef struct packed {
    logic [ectc_pkg::YearW-1:0]   year;
    logic [ectc_pkg::MonthW-1:0]  month;
    logic [ectc_pkg::DayW-1:0]    day_of_month;
    logic [ectc_pkg::Hour24W-1:0] hour_24;
    logic [ectc_pkg::Hour12W-1:0] hour_12;
    logic                         is_pm;
    logic [ectc_pkg::MinW-1:0]    minute;
    logic [ectc_pkg::SecW-1:0]    second;
  } civil_date_t;

  // Expected calendar dates, one per accepted epoch beat, oldest first
  class date_ledger;
    civil_date_t expected_dates[$];
    int unsigned mismatch_count = 0;

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Split the second count into days and time of day, then walk years and months
    function civil_date_t civil_of_epoch(logic [ectc_pkg::SecsW-1:0] secs);
      int unsigned mlen_tbl[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      int unsigned days;
      int unsigned tod;
      int unsigned yr;
      int unsigned mon;
      int unsigned mlen;
      int unsigned h24;
      civil_date_t d;
      days = secs / ectc_pkg::SecsPerDay;
      tod  = secs % ectc_pkg::SecsPerDay;
      yr   = 1970;
      while (days >= 365 + leap_year(yr)) begin
        days -= 365 + leap_year(yr);
        yr++;
      end
      mon = 0;
      while (mon < 11) begin
        mlen = mlen_tbl[mon];
        if (mon == 1 && leap_year(yr)) mlen = 29;
        if (days < mlen) break;
        days -= mlen;
        mon++;
      end
      h24 = tod / ectc_pkg::SecsPerHour;
      d.year         = ectc_pkg::YearW'(yr);
      d.month        = ectc_pkg::MonthW'(mon + 1);
      d.day_of_month = ectc_pkg::DayW'(days + 1);
      d.hour_24      = ectc_pkg::Hour24W'(h24);
      d.hour_12      = ectc_pkg::Hour12W'((h24 == 0) ? 12 : (h24 > 12) ? h24 - 12 : h24);
      d.is_pm        = (h24 >= 12);
      d.minute       = ectc_pkg::MinW'((tod % ectc_pkg::SecsPerHour) / ectc_pkg::SecsPerMin);
      d.second       = ectc_pkg::SecW'(tod % ectc_pkg::SecsPerMin);
      return d;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    function void note_epoch(logic [ectc_pkg::SecsW-1:0] secs);
      expected_dates.push_back(civil_of_epoch(secs));
    endfunction

    task check_date(civil_date_t got);
      civil_date_t want;
      if (expected_dates.size() == 0) begin
        report($sformatf("result with nothing pending, year %0d", got.year));
        return;
      end
      want = expected_dates.pop_front();
      if (got.year !== want.year)
        report($sformatf("year got %0d want %0d", got.year, want.year));
      if (got.month !== want.month)
        report($sformatf("month got %0d want %0d", got.month, want.month));
      if (got.day_of_month !== want.day_of_month)
        report($sformatf("day got %0d want %0d", got.day_of_month, want.day_of_month));
      if (got.hour_24 !== want.hour_24)
        report($sformatf("hour_24 got %0d want %0d", got.hour_24, want.hour_24));
      if (got.hour_12 !== want.hour_12)
        report($sformatf("hour_12 got %0d want %0d", got.hour_12, want.hour_12));
      if (got.is_pm !== want.is_pm)
        report($sformatf("is_pm got %0b want %0b", got.is_pm, want.is_pm));
      if (got.minute !== want.minute)
        report($sformatf("minute got %0d want %0d", got.minute, want.minute));
      if (got.second !== want.second)
        report($sformatf("second got %0d want %0d", got.second, want.second));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  date_ledger ledger = new();

  ectc_in_if  in_if();
  ectc_out_if out_if();

  epoch_to_calendar_time uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Watch both channels and score each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) ledger.note_epoch(in_if.epoch_seconds);
      if (out_if.valid && out_if.ready)
        ledger.check_date('{out_if.year, out_if.month, out_if.day_of_month, out_if.hour_24,
                            out_if.hour_12, out_if.is_pm, out_if.minute, out_if.second});
    end
  end

  // Stall the receiver at random
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Present one epoch beat after random idle cycles, hold until accepted
  task drive_epoch(logic [ectc_pkg::SecsW-1:0] secs);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.epoch_seconds <= secs;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Random epochs: half anywhere, half near day and hour boundaries
  task drive_random(int unsigned count);
    logic [63:0] wide;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(3);
      case (pick)
        2: wide = 64'($urandom_range(49710)) * ectc_pkg::SecsPerDay
                  + ($urandom_range(1) ? $urandom_range(2) : 86397 + $urandom_range(2));
        3: wide = 64'($urandom_range(49710)) * ectc_pkg::SecsPerDay
                  + $urandom_range(23) * ectc_pkg::SecsPerHour
                  + ($urandom_range(1) ? $urandom_range(1) : 3599);
        default: wide = 64'($urandom);
      endcase
      if (wide > 64'hFFFF_FFFF) wide = 64'($urandom);
      drive_epoch(wide[31:0]);
    end
  endtask

  task wait_drained();
    while (ledger.expected_dates.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [ectc_pkg::SecsW-1:0] directed[$] = '{
      32'd0, 32'hFFFF_FFFF, 32'd43199, 32'd43200, 32'd46800, 32'd86399, 32'd3600,
      32'd94694399, 32'd94694400,          // end of leap year 1972 and the day after
      32'd946684800, 32'd951782400,        // 2000 starts, 29 Feb 2000
      32'd978307199,                       // last second of leap year 2000
      32'd4107542399, 32'd4107542400,      // 2100 skips its leap day
      32'd2147483647, 32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA
    };
    in_if.valid         <= 1'b0;
    in_if.epoch_seconds <= '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed edges, no idling
    foreach (directed[i]) drive_epoch(directed[i]);
    drive_random(400);

    // Sparse sender, with one full drain in the middle
    idle_pct = 86;
    drive_random(200);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    drive_random(200);

    // Slow receiver
    idle_pct  = 0;
    stall_pct = 86;
    drive_random(400);

    // Both sides idle
    idle_pct  = 38;
    stall_pct = 38;
    drive_random(400);

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (ledger.mismatch_count == 0 && ledger.expected_dates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ectc_pkg.sv
rtl/core/ectc_if.sv
rtl/core/ectc_tod.sv
rtl/core/ectc_date.sv
rtl/core/epoch_to_calendar_time.sv
test/tb_epoch_to_calendar_time.sv
